@@ rtl/rse_pkg.sv @@
// Shared types and codes for the RPN stack evaluator.
package rse_pkg;

    localparam int WORD_W = 32;

    typedef enum logic [3:0] {
        KIND_PUSH    = 4'd0,
        KIND_ADD     = 4'd1,
        KIND_SUB     = 4'd2,
        KIND_MUL     = 4'd3,
        KIND_DROP    = 4'd4,
        KIND_PRINT   = 4'd5,
        KIND_READ    = 4'd6,
        KIND_WRITE   = 4'd7,
        KIND_LOCK    = 4'd8,
        KIND_ANSWER  = 4'd9,
        KIND_UNKNOWN = 4'd10
    } t_kind;

    typedef enum logic [2:0] {
        ACT_PRINT = 3'd0,
        ACT_READ  = 3'd1,
        ACT_WRITE = 3'd2,
        ACT_LOCK  = 3'd3,
        ACT_ERROR = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_BOUNDS  = 2'd1,
        ERR_UNKNOWN = 2'd2
    } t_err;

    // Where a stack cell takes its next word from.
    typedef enum logic [1:0] {
        SH_HOLD      = 2'd0,
        SH_FROM_UP   = 2'd1,
        SH_FROM_NEXT = 2'd2,
        SH_FROM_SKIP = 2'd3
    } t_shift;

    typedef enum logic {
        REG_USER_ID_LOW  = 1'b0,
        REG_USER_ID_HIGH = 1'b1
    } t_reg;

endpackage

@@ rtl/rpn_stack_evaluator.sv @@
// Top level of the RPN stack evaluator: control, chain of stack cells, config port.
//
//   channel   direction  beat contents
//   s_axis    in         tuser = kind, tdata = operand
//   m_axis    out        tuser = action, tdata = slot_index, data_value, error_code
//   apb       in/out     user_id_low at 0x0, user_id_high at 0x4
//
// The stack is a chain of cells that all shift in the same clock edge, with the
// top word in cell zero. A new token is taken while the output register is empty
// or its beat is taken. Reset clears the top pointer, the pending-read flag, the
// halt flag and the output valid flag; cell contents are not cleared, and no
// clearing pass runs.
module rpn_stack_evaluator #(
    parameter int STACK_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] operand
    input  logic [3:0]  i_s_axis_tuser,   // [3:0] kind
    // master side
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [71:0] o_m_axis_tdata,   // [31:0] slot_index, [63:32] data_value,
                                          // [65:64] error_code, [71:66] zero
    output logic [2:0]  o_m_axis_tuser,   // [2:0] action
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rse_pkg::*;

    localparam int TOP_W = $clog2(STACK_DEPTH + 1);

    logic [WORD_W-1:0] w_cell [STACK_DEPTH];
    t_shift            w_op_first;
    t_shift            w_op_rest;
    logic [WORD_W-1:0] w_first_in;
    logic [WORD_W-1:0] w_alu;

    logic [TOP_W-1:0]  r_top, n_top;
    logic              r_await, n_await;
    logic              r_halted, n_halted;
    logic              r_out_valid, n_out_valid;
    t_action           r_action, n_action;
    logic [WORD_W-1:0] r_slot, n_slot;
    logic [WORD_W-1:0] r_data, n_data;
    t_err              r_err, n_err;
    logic [WORD_W-1:0] r_uid_low;
    logic [WORD_W-1:0] r_uid_high;

    logic              w_accept;
    t_kind             w_kind;
    logic [1:0]        w_need;
    logic              w_known;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uid_low  <= '0;
            r_uid_high <= '0;
        end else if (psel && penable && pwrite && pready) begin
            if (t_reg'(paddr[2]) == REG_USER_ID_HIGH) begin
                r_uid_high <= pwdata;
            end else begin
                r_uid_low <= pwdata;
            end
        end
    end

    assign prdata = (t_reg'(paddr[2]) == REG_USER_ID_HIGH) ? r_uid_high : r_uid_low;

    // ---------------- stack cell chain ----------------
    for (genvar k = 0; k < STACK_DEPTH; k++) begin : g_cell
        logic [WORD_W-1:0] w_up;
        logic [WORD_W-1:0] w_next;
        logic [WORD_W-1:0] w_skip;
        if (k == 0) begin : g_first
            assign w_up = w_first_in;
        end else begin : g_mid
            assign w_up = w_cell[k-1];
        end
        if (k + 1 < STACK_DEPTH) begin : g_n1
            assign w_next = w_cell[k+1];
        end else begin : g_n1z
            assign w_next = '0;
        end
        if (k + 2 < STACK_DEPTH) begin : g_n2
            assign w_skip = w_cell[k+2];
        end else begin : g_n2z
            assign w_skip = '0;
        end
        rse_cell u_cell (
            .i_clk  (i_clk),
            .i_op   ((k == 0) ? w_op_first : w_op_rest),
            .i_up   (w_up),
            .i_next (w_next),
            .i_skip (w_skip),
            .o_word (w_cell[k])
        );
    end

    rse_alu u_alu (
        .i_kind   (w_kind),
        .i_a      (w_cell[1]),
        .i_b      (w_cell[0]),
        .o_result (w_alu)
    );

    // ---------------- token control ----------------
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_kind          = t_kind'(i_s_axis_tuser);

    always_comb begin
        w_known = 1'b1;
        case (w_kind)
            KIND_PUSH, KIND_ANSWER:                  w_need = 2'd0;
            KIND_ADD, KIND_SUB, KIND_MUL, KIND_WRITE: w_need = 2'd2;
            KIND_DROP, KIND_PRINT, KIND_READ, KIND_LOCK: w_need = 2'd1;
            default: begin
                w_need  = 2'd0;
                w_known = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_top       = r_top;
        n_await     = r_await;
        n_halted    = r_halted;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_action    = r_action;
        n_slot      = r_slot;
        n_data      = r_data;
        n_err       = r_err;
        w_op_first  = SH_HOLD;
        w_op_rest   = SH_HOLD;
        w_first_in  = i_s_axis_tdata;

        if (w_accept && !r_halted) begin
            if (r_await) begin
                // The pending read freed the top entry, so the answer always fits.
                if (w_kind == KIND_ANSWER) begin
                    n_await    = 1'b0;
                    w_op_first = SH_FROM_UP;
                    w_op_rest  = SH_FROM_UP;
                    n_top      = r_top + TOP_W'(1);
                end
            end else if (w_kind == KIND_ANSWER) begin
                n_await = 1'b0;
            end else if (!w_known
                         || r_top < TOP_W'(w_need)
                         || r_top >= TOP_W'(STACK_DEPTH)) begin
                n_halted    = 1'b1;
                n_out_valid = 1'b1;
                n_action    = ACT_ERROR;
                n_slot      = '0;
                n_data      = '0;
                n_err       = w_known ? ERR_BOUNDS : ERR_UNKNOWN;
            end else begin
                case (w_kind)
                    KIND_PUSH: begin
                        w_op_first = SH_FROM_UP;
                        w_op_rest  = SH_FROM_UP;
                        n_top      = r_top + TOP_W'(1);
                    end
                    KIND_ADD, KIND_SUB, KIND_MUL: begin
                        w_first_in = w_alu;
                        w_op_first = SH_FROM_UP;
                        w_op_rest  = SH_FROM_NEXT;
                        n_top      = r_top - TOP_W'(1);
                    end
                    KIND_DROP: begin
                        w_op_first = SH_FROM_NEXT;
                        w_op_rest  = SH_FROM_NEXT;
                        n_top      = r_top - TOP_W'(1);
                    end
                    KIND_PRINT: begin
                        n_out_valid = 1'b1;
                        n_action    = ACT_PRINT;
                        n_slot      = '0;
                        n_data      = w_cell[0];
                        n_err       = ERR_NONE;
                    end
                    KIND_READ, KIND_LOCK: begin
                        w_op_first  = SH_FROM_NEXT;
                        w_op_rest   = SH_FROM_NEXT;
                        n_top       = r_top - TOP_W'(1);
                        n_await     = (w_kind == KIND_READ);
                        n_out_valid = 1'b1;
                        n_action    = (w_kind == KIND_READ) ? ACT_READ : ACT_LOCK;
                        n_slot      = w_cell[0];
                        n_data      = '0;
                        n_err       = ERR_NONE;
                    end
                    KIND_WRITE: begin
                        w_op_first  = SH_FROM_SKIP;
                        w_op_rest   = SH_FROM_SKIP;
                        n_top       = r_top - TOP_W'(2);
                        n_out_valid = 1'b1;
                        n_action    = ACT_WRITE;
                        n_slot      = w_cell[0];
                        n_data      = w_cell[1];
                        n_err       = ERR_NONE;
                    end
                    default: begin
                        n_top = r_top;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top       <= '0;
            r_await     <= 1'b0;
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_top       <= n_top;
            r_await     <= n_await;
            r_halted    <= n_halted;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_slot   <= n_slot;
        r_data   <= n_data;
        r_err    <= n_err;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_action;
    assign o_m_axis_tdata  = {6'd0, r_err, r_data, r_slot};

`ifndef SYNTHESIS
    a_top_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= TOP_W'(STACK_DEPTH))
        else $error("stack top beyond depth");

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halt flag cleared without reset");

    a_error_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_action == ACT_ERROR) |-> r_halted)
        else $error("error beat without halt");

    a_no_await_when_halted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_await && r_halted))
        else $error("pending read while halted");
`endif

endmodule

@@ rtl/rse_cell.sv @@
// One stack cell: holds a single word and moves it along the chain.
module rse_cell (
    input  logic                      i_clk,
    input  rse_pkg::t_shift           i_op,
    input  logic [rse_pkg::WORD_W-1:0] i_up,
    input  logic [rse_pkg::WORD_W-1:0] i_next,
    input  logic [rse_pkg::WORD_W-1:0] i_skip,
    output logic [rse_pkg::WORD_W-1:0] o_word
);
    import rse_pkg::*;

    logic [WORD_W-1:0] r_word;

    always_ff @(posedge i_clk) begin
        case (i_op)
            SH_FROM_UP:   r_word <= i_up;
            SH_FROM_NEXT: r_word <= i_next;
            SH_FROM_SKIP: r_word <= i_skip;
            default:      r_word <= r_word;
        endcase
    end

    assign o_word = r_word;

endmodule

@@ rtl/rse_alu.sv @@
// Wrapping 32-bit add, subtract and multiply on the two top stack words.
module rse_alu (
    input  rse_pkg::t_kind             i_kind,
    input  logic [rse_pkg::WORD_W-1:0] i_a,
    input  logic [rse_pkg::WORD_W-1:0] i_b,
    output logic [rse_pkg::WORD_W-1:0] o_result
);
    import rse_pkg::*;

    logic [2*WORD_W-1:0] w_prod;

    assign w_prod = i_a * i_b;

    always_comb begin
        case (i_kind)
            KIND_ADD: o_result = i_a + i_b;
            KIND_SUB: o_result = i_a - i_b;
            KIND_MUL: o_result = w_prod[WORD_W-1:0];
            default:  o_result = i_a;
        endcase
    end

endmodule
